// ===== sv/mse_pkg.sv =====
// Shared types, opcodes and constants for the MIPS subset execute unit.
package mse_pkg;

	localparam int          DATA_BYTES_DEF = 1024;
	localparam int          NUM_REGS       = 32;
	localparam int          REG_IDX_W      = 5;
	localparam int          LANES          = 4;
	localparam int          LUI_SHIFT      = 16;
	localparam logic [4:0]  LINK_REG       = 5'd31;
	localparam logic [31:0] PC_REGION_MASK = 32'hF000_0000;

	typedef enum logic [4:0] {
		OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_NOR, OP_NAND, OP_SLT,
		OP_SLL, OP_SRL, OP_SRA, OP_JR, OP_ADDI, OP_LW, OP_LH, OP_LHU,
		OP_LB, OP_LBU, OP_SW, OP_SH, OP_SB, OP_LUI, OP_ANDI, OP_ORI,
		OP_NORI, OP_SLTI, OP_BEQ, OP_BNE, OP_J, OP_JAL
	} op_t;

	typedef enum logic [2:0] {
		LD_NONE, LD_W, LD_H, LD_HU, LD_B, LD_BU
	} ld_kind_t;

	// Result of one instruction, as it travels to the output stage
	typedef struct packed {
		logic [31:0]          next_pc;
		logic                 reg_write;
		logic [REG_IDX_W-1:0] widx;
		logic [31:0]          wvalue;
		logic                 ovf;
		logic                 mis;
		ld_kind_t             ld_kind;
		logic [1:0]           lane;
	} res_t;

	// Execute output: result plus the data memory request
	typedef struct packed {
		res_t             res;
		logic             mem_we;
		logic             mem_re;
		logic [LANES-1:0] be;
		logic [31:0]      wdata;
		logic [31:0]      addr;
	} exec_t;

endpackage

// ===== sv/mse_regfile.sv =====
// General register file: 32 entries, two registered read ports, write-through bypass.
module mse_regfile (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [mse_pkg::REG_IDX_W-1:0] rd_addr_a,
	input  logic [mse_pkg::REG_IDX_W-1:0] rd_addr_b,
	output logic [31:0]                   rd_a_s1,
	output logic [31:0]                   rd_b_s1,
	input  logic                          we,
	input  logic [mse_pkg::REG_IDX_W-1:0] waddr,
	input  logic [31:0]                   wdata
);
	import mse_pkg::*;

	logic [31:0]         mem_q [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;

	// track written entries; unwritten ones read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read ports, passing a same-edge write straight through
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (we && waddr == rd_addr_a) begin
				rd_a_s1 <= wdata;
			end else begin
				rd_a_s1 <= vld_q[rd_addr_a] ? mem_q[rd_addr_a] : 32'h0;
			end
			if (we && waddr == rd_addr_b) begin
				rd_b_s1 <= wdata;
			end else begin
				rd_b_s1 <= vld_q[rd_addr_b] ? mem_q[rd_addr_b] : 32'h0;
			end
		end
	end

endmodule

// ===== sv/mse_alu.sv =====
// Execute logic: ALU, shifts, compares, address and bounds checks, next pc.
module mse_alu #(
	parameter int DATA_BYTES = mse_pkg::DATA_BYTES_DEF
) (
	input  mse_pkg::op_t                  op,
	input  logic [mse_pkg::REG_IDX_W-1:0] rd,
	input  logic [mse_pkg::REG_IDX_W-1:0] rt,
	input  logic [4:0]                    sh,
	input  logic [25:0]                   imm,
	input  logic [31:0]                   a,
	input  logic [31:0]                   b,
	input  logic [31:0]                   pc,
	output mse_pkg::exec_t                ex
);
	import mse_pkg::*;

	localparam logic [31:0] LIM_W = 32'(DATA_BYTES - 4);
	localparam logic [31:0] LIM_H = 32'(DATA_BYTES - 2);
	localparam logic [31:0] LIM_B = 32'(DATA_BYTES - 1);

	logic [31:0] simm, u16, pc4, addr, br_tgt, jmp_tgt;
	logic        ovf_w, ovf_h, ovf_b, mis_w, mis_h;

	// operands and targets
	assign simm    = {{16{imm[15]}}, imm[15:0]};
	assign u16     = {16'h0, imm[15:0]};
	assign pc4     = pc + 32'd4;
	assign addr    = a + simm;
	assign br_tgt  = pc4 + {simm[29:0], 2'b00};
	assign jmp_tgt = (pc4 & PC_REGION_MASK) | {4'h0, imm, 2'b00};

	// bounds and alignment per access size
	assign ovf_w = addr[31] || (addr > LIM_W);
	assign ovf_h = addr[31] || (addr > LIM_H);
	assign ovf_b = addr[31] || (addr > LIM_B);
	assign mis_w = |addr[1:0];
	assign mis_h = addr[0];

	// decode and execute
	always_comb begin
		ex             = '0;
		ex.res.next_pc = pc4;
		ex.res.lane    = addr[1:0];
		ex.addr        = addr;
		unique case (op)
			OP_ADD: begin
				ex.res.wvalue = a + b; ex.res.widx = rd; ex.res.reg_write = 1'b1;
			end
			OP_SUB: begin
				ex.res.wvalue = a - b; ex.res.widx = rd; ex.res.reg_write = 1'b1;
			end
			OP_AND: begin
				ex.res.wvalue = a & b; ex.res.widx = rd; ex.res.reg_write = 1'b1;
			end
			OP_OR: begin
				ex.res.wvalue = a | b; ex.res.widx = rd; ex.res.reg_write = 1'b1;
			end
			OP_XOR: begin
				ex.res.wvalue = a ^ b; ex.res.widx = rd; ex.res.reg_write = 1'b1;
			end
			OP_NOR: begin
				ex.res.wvalue = ~(a | b); ex.res.widx = rd; ex.res.reg_write = 1'b1;
			end
			OP_NAND: begin
				ex.res.wvalue = ~(a & b); ex.res.widx = rd; ex.res.reg_write = 1'b1;
			end
			OP_SLT: begin
				ex.res.wvalue = {31'h0, $signed(a) < $signed(b)};
				ex.res.widx = rd; ex.res.reg_write = 1'b1;
			end
			OP_SLL: begin
				ex.res.wvalue = b << sh; ex.res.widx = rd; ex.res.reg_write = 1'b1;
			end
			OP_SRL: begin
				ex.res.wvalue = b >> sh; ex.res.widx = rd; ex.res.reg_write = 1'b1;
			end
			OP_SRA: begin
				ex.res.wvalue = $unsigned($signed(b) >>> sh);
				ex.res.widx = rd; ex.res.reg_write = 1'b1;
			end
			OP_JR: begin
				ex.res.next_pc = a;
			end
			OP_ADDI: begin
				ex.res.wvalue = addr; ex.res.widx = rt; ex.res.reg_write = 1'b1;
			end
			OP_LW: begin
				ex.res.ovf = ovf_w; ex.res.mis = mis_w;
				if (!ovf_w && !mis_w) begin
					ex.res.reg_write = 1'b1; ex.res.widx = rt;
					ex.res.ld_kind = LD_W; ex.mem_re = 1'b1;
				end
			end
			OP_LH: begin
				ex.res.ovf = ovf_h; ex.res.mis = mis_h;
				if (!ovf_h && !mis_h) begin
					ex.res.reg_write = 1'b1; ex.res.widx = rt;
					ex.res.ld_kind = LD_H; ex.mem_re = 1'b1;
				end
			end
			OP_LHU: begin
				ex.res.ovf = ovf_h; ex.res.mis = mis_h;
				if (!ovf_h && !mis_h) begin
					ex.res.reg_write = 1'b1; ex.res.widx = rt;
					ex.res.ld_kind = LD_HU; ex.mem_re = 1'b1;
				end
			end
			OP_LB: begin
				ex.res.ovf = ovf_b;
				if (!ovf_b) begin
					ex.res.reg_write = 1'b1; ex.res.widx = rt;
					ex.res.ld_kind = LD_B; ex.mem_re = 1'b1;
				end
			end
			OP_LBU: begin
				ex.res.ovf = ovf_b;
				if (!ovf_b) begin
					ex.res.reg_write = 1'b1; ex.res.widx = rt;
					ex.res.ld_kind = LD_BU; ex.mem_re = 1'b1;
				end
			end
			OP_SW: begin
				ex.res.ovf = ovf_w; ex.res.mis = mis_w;
				ex.mem_we = !ovf_w && !mis_w;
				ex.be     = 4'b1111;
				ex.wdata  = b;
			end
			OP_SH: begin
				ex.res.ovf = ovf_h; ex.res.mis = mis_h;
				ex.mem_we = !ovf_h && !mis_h;
				ex.be     = addr[1] ? 4'b0011 : 4'b1100;
				ex.wdata  = {2{b[15:0]}};
			end
			OP_SB: begin
				ex.res.ovf = ovf_b;
				ex.mem_we = !ovf_b;
				ex.be     = 4'b1000 >> addr[1:0];
				ex.wdata  = {4{b[7:0]}};
			end
			OP_LUI: begin
				ex.res.wvalue = u16 << LUI_SHIFT;
				ex.res.widx = rt; ex.res.reg_write = 1'b1;
			end
			OP_ANDI: begin
				ex.res.wvalue = a & u16; ex.res.widx = rt; ex.res.reg_write = 1'b1;
			end
			OP_ORI: begin
				ex.res.wvalue = a | u16; ex.res.widx = rt; ex.res.reg_write = 1'b1;
			end
			OP_NORI: begin
				ex.res.wvalue = ~(a | u16); ex.res.widx = rt; ex.res.reg_write = 1'b1;
			end
			OP_SLTI: begin
				ex.res.wvalue = {31'h0, $signed(a) < $signed(simm)};
				ex.res.widx = rt; ex.res.reg_write = 1'b1;
			end
			OP_BEQ: begin
				if (a == b) ex.res.next_pc = br_tgt;
			end
			OP_BNE: begin
				if (a != b) ex.res.next_pc = br_tgt;
			end
			OP_J: begin
				ex.res.next_pc = jmp_tgt;
			end
			OP_JAL: begin
				ex.res.next_pc = jmp_tgt;
				ex.res.wvalue = pc4; ex.res.widx = LINK_REG; ex.res.reg_write = 1'b1;
			end
			default: begin
				// unused codes: pc advances, nothing else changes
			end
		endcase
	end

endmodule

// ===== sv/mse_dmem.sv =====
// Big-endian byte data memory as 32-bit words with byte enables and a clearing pass.
module mse_dmem #(
	parameter int DATA_BYTES = mse_pkg::DATA_BYTES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	output logic                      busy,
	input  logic [31:0]               addr,
	input  logic                      we,
	input  logic [mse_pkg::LANES-1:0] be,
	input  logic [31:0]               wdata,
	input  logic                      re,
	output logic [31:0]               rd_data_s2
);
	import mse_pkg::*;

	localparam int WORDS  = (DATA_BYTES + LANES - 1) / LANES;
	localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam logic [WIDX_W-1:0] LAST_IDX = WIDX_W'(WORDS - 1);

	logic [LANES-1:0][7:0] mem_q [WORDS];
	logic [WIDX_W-1:0]     clr_idx_q;
	logic                  clr_busy_q;
	logic [WIDX_W-1:0]     widx;

	assign widx = addr[2 +: WIDX_W];
	assign busy = clr_busy_q;

	// sweep every word to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			if (clr_idx_q == LAST_IDX) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	// write port: clearing pass, else byte-enabled store
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem_q[clr_idx_q] <= '0;
		end else if (we) begin
			for (int j = 0; j < LANES; j++) begin
				if (be[j]) mem_q[widx][j] <= wdata[8*j +: 8];
			end
		end
	end

	// registered read, held until the next load
	always_ff @(posedge clk) begin
		if (re) begin
			rd_data_s2 <= mem_q[widx];
		end
	end

endmodule

// ===== sv/mips_subset_execute_unit.sv =====
// Top level: input stage, execute, result stage with load alignment and forwarding.
// Input beats are registered in s1 and results in s2. Throughput: one instruction
// per cycle while out_ready stays high; execute is a single pass from the s1
// operand registers to the s2 result register, loads read the one-port data memory.
// Reset: registers and pc clear at once; the data memory is then swept to zero
// word by word, with in_ready held low until the sweep ends.
module mips_subset_execute_unit #(
	parameter int DATA_BYTES = mse_pkg::DATA_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [4:0]                    op,
	input  logic [mse_pkg::REG_IDX_W-1:0] dest_index,
	input  logic [mse_pkg::REG_IDX_W-1:0] src_index,
	input  logic [mse_pkg::REG_IDX_W-1:0] tgt_index,
	input  logic [4:0]                    shift_amount,
	input  logic [25:0]                   immediate,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [31:0]                   next_pc,
	output logic                          reg_write,
	output logic [mse_pkg::REG_IDX_W-1:0] written_index,
	output logic signed [31:0]            written_value,
	output logic                          address_overflow,
	output logic                          misaligned
);
	import mse_pkg::*;

	logic                 vld_s1, vld_s2;
	op_t                  op_s1;
	logic [REG_IDX_W-1:0] rd_s1, rs_s1, rt_s1;
	logic [4:0]           sh_s1;
	logic [25:0]          imm_s1;
	res_t                 res_s2;
	logic [31:0]          pc_q;

	logic        in_acc, s1_adv, clr_busy, rf_we;
	logic [31:0] rd_a_s1, rd_b_s1, fwd_a, fwd_b, rd_data_s2, wval_s2;
	logic [15:0] half_s2;
	logic [7:0]  byte_s2;
	exec_t       ex;

	// handshake: s1 moves on when s2 is free or draining
	assign s1_adv   = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !clr_busy && (!vld_s1 || s1_adv);
	assign in_acc   = in_valid && in_ready;
	assign rf_we    = vld_s2 && out_ready && res_s2.reg_write;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (s1_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1  <= op_t'(op);
			rd_s1  <= dest_index;
			rs_s1  <= src_index;
			rt_s1  <= tgt_index;
			sh_s1  <= shift_amount;
			imm_s1 <= immediate;
		end
	end

	mse_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (in_acc),
		.rd_addr_a (src_index),
		.rd_addr_b (tgt_index),
		.rd_a_s1   (rd_a_s1),
		.rd_b_s1   (rd_b_s1),
		.we        (rf_we),
		.waddr     (res_s2.widx),
		.wdata     (wval_s2)
	);

	// forward the result still waiting in s2
	always_comb begin
		fwd_a = rd_a_s1;
		fwd_b = rd_b_s1;
		if (vld_s2 && res_s2.reg_write && res_s2.widx == rs_s1) fwd_a = wval_s2;
		if (vld_s2 && res_s2.reg_write && res_s2.widx == rt_s1) fwd_b = wval_s2;
	end

	mse_alu #(.DATA_BYTES(DATA_BYTES)) u_alu (
		.op  (op_s1),
		.rd  (rd_s1),
		.rt  (rt_s1),
		.sh  (sh_s1),
		.imm (imm_s1),
		.a   (fwd_a),
		.b   (fwd_b),
		.pc  (pc_q),
		.ex  (ex)
	);

	mse_dmem #(.DATA_BYTES(DATA_BYTES)) u_dmem (
		.clk        (clk),
		.arst_n     (arst_n),
		.busy       (clr_busy),
		.addr       (ex.addr),
		.we         (s1_adv && ex.mem_we),
		.be         (ex.be),
		.wdata      (ex.wdata),
		.re         (s1_adv && ex.mem_re),
		.rd_data_s2 (rd_data_s2)
	);

	// advance pc as each instruction leaves s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= 32'h0;
		end else if (s1_adv) begin
			pc_q <= ex.res.next_pc;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s1_adv) begin
			vld_s2 <= 1'b1;
		end else if (out_ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_s2 <= ex.res;
		end
	end

	// pick the loaded lanes, big-endian
	assign half_s2 = res_s2.lane[1] ? rd_data_s2[15:0] : rd_data_s2[31:16];

	always_comb begin
		case (res_s2.lane)
			2'd0:    byte_s2 = rd_data_s2[31:24];
			2'd1:    byte_s2 = rd_data_s2[23:16];
			2'd2:    byte_s2 = rd_data_s2[15:8];
			default: byte_s2 = rd_data_s2[7:0];
		endcase
	end

	always_comb begin
		case (res_s2.ld_kind)
			LD_W:    wval_s2 = rd_data_s2;
			LD_H:    wval_s2 = {{16{half_s2[15]}}, half_s2};
			LD_HU:   wval_s2 = {16'h0, half_s2};
			LD_B:    wval_s2 = {{24{byte_s2[7]}}, byte_s2};
			LD_BU:   wval_s2 = {24'h0, byte_s2};
			default: wval_s2 = res_s2.wvalue;
		endcase
	end

	// drive the result beat
	assign out_valid        = vld_s2;
	assign next_pc          = res_s2.next_pc;
	assign reg_write        = res_s2.reg_write;
	assign written_index    = res_s2.widx;
	assign written_value    = wval_s2;
	assign address_overflow = res_s2.ovf;
	assign misaligned       = res_s2.mis;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the MIPS subset execute unit: directed and random instruction streams.
module testbench;
	import mse_pkg::*;

	localparam int          DATA_BYTES   = DATA_BYTES_DEF;
	localparam int          RANDOM_ITEMS = 1000;
	localparam int          HOLD_CYCLES  = 80;
	localparam int          PRINT_LIMIT  = 50;
	localparam int unsigned CYCLE_LIMIT  = 200_000;

	// Op codes outside the subset; the block treats them as no-ops
	localparam logic [4:0] OP_RSVD_A = 5'd30;
	localparam logic [4:0] OP_RSVD_B = 5'd31;

	typedef struct {
		logic [31:0] npc;
		logic        wr;
		logic [4:0]  widx;
		logic [31:0] wval;
		logic        ovf;
		logic        mis;
	} retire_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [4:0]           op;
	logic [REG_IDX_W-1:0] dest_index;
	logic [REG_IDX_W-1:0] src_index;
	logic [REG_IDX_W-1:0] tgt_index;
	logic [4:0]           shift_amount;
	logic [25:0]          immediate;
	logic                 out_valid;
	logic                 out_ready;
	logic [31:0]          next_pc;
	logic                 reg_write;
	logic [REG_IDX_W-1:0] written_index;
	logic signed [31:0]   written_value;
	logic                 address_overflow;
	logic                 misaligned;

	// Shadow architectural state
	logic [31:0] gpr [NUM_REGS];
	logic [31:0] pc;
	logic [7:0]  dmem [DATA_BYTES];

	retire_t     retire_queue [$];
	int          mismatch_count = 0;
	int          sent_count = 0;
	int unsigned cycle_count = 0;
	logic        hold_request;
	logic        hold_active;

	mips_subset_execute_unit #(.DATA_BYTES(DATA_BYTES)) uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Execute one instruction on the shadow state and return its retirement
	function automatic retire_t run_instr(input logic [4:0] code, input logic [4:0] rd,
			input logic [4:0] rs, input logic [4:0] rt, input logic [4:0] sh,
			input logic [25:0] imm);
		logic [31:0] a, b, u16, simm, pc4, npc, addr, val, size;
		logic [4:0]  widx;
		logic        wr, ovf, mis;
		retire_t     r;
		a    = gpr[rs];
		b    = gpr[rt];
		u16  = {16'd0, imm[15:0]};
		simm = {{16{imm[15]}}, imm[15:0]};
		pc4  = pc + 32'd4;
		npc  = pc4;
		addr = a + simm;
		val  = '0;
		widx = '0;
		wr   = 1'b0;
		ovf  = 1'b0;
		mis  = 1'b0;

		// Size and bounds of a memory access
		case (code)
			OP_LW, OP_SW:         size = 32'd4;
			OP_LH, OP_LHU, OP_SH: size = 32'd2;
			OP_LB, OP_LBU, OP_SB: size = 32'd1;
			default:              size = 32'd0;
		endcase
		if (size != 0) begin
			ovf = addr[31] || (addr > 32'(DATA_BYTES) - size);
			mis = (addr & (size - 32'd1)) != 0;
		end

		case (code)
			OP_ADD:  begin val = a + b;     widx = rd; wr = 1'b1; end
			OP_SUB:  begin val = a - b;     widx = rd; wr = 1'b1; end
			OP_AND:  begin val = a & b;     widx = rd; wr = 1'b1; end
			OP_OR:   begin val = a | b;     widx = rd; wr = 1'b1; end
			OP_XOR:  begin val = a ^ b;     widx = rd; wr = 1'b1; end
			OP_NOR:  begin val = ~(a | b);  widx = rd; wr = 1'b1; end
			OP_NAND: begin val = ~(a & b);  widx = rd; wr = 1'b1; end
			OP_SLT: begin
				val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
				widx = rd; wr = 1'b1;
			end
			OP_SLL:  begin val = b << sh;            widx = rd; wr = 1'b1; end
			OP_SRL:  begin val = b >> sh;            widx = rd; wr = 1'b1; end
			OP_SRA:  begin val = $signed(b) >>> sh;  widx = rd; wr = 1'b1; end
			OP_JR:   npc = a;
			OP_ADDI: begin val = a + simm; widx = rt; wr = 1'b1; end
			OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU: begin
				if (!(ovf || mis)) begin
					for (int i = 0; i < size; i++)
						val = {val[23:0], dmem[addr + i]};
					if (code == OP_LH)
						val = {{16{val[15]}}, val[15:0]};
					else if (code == OP_LB)
						val = {{24{val[7]}}, val[7:0]};
					widx = rt;
					wr = 1'b1;
				end
			end
			OP_SW, OP_SH, OP_SB: begin
				// Store big-endian, most significant byte at the lowest address
				if (!(ovf || mis))
					for (int i = 0; i < size; i++)
						dmem[addr + i] = 8'(b >> (8 * (size - 1 - i)));
			end
			OP_LUI:  begin val = {imm[15:0], 16'd0}; widx = rt; wr = 1'b1; end
			OP_ANDI: begin val = a & u16;            widx = rt; wr = 1'b1; end
			OP_ORI:  begin val = a | u16;            widx = rt; wr = 1'b1; end
			OP_NORI: begin val = ~(a | u16);         widx = rt; wr = 1'b1; end
			OP_SLTI: begin
				val = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
				widx = rt; wr = 1'b1;
			end
			OP_BEQ:  if (a == b) npc = pc4 + (simm << 2);
			OP_BNE:  if (a != b) npc = pc4 + (simm << 2);
			OP_J:    npc = (pc4 & PC_REGION_MASK) | {4'd0, imm, 2'b00};
			OP_JAL: begin
				val  = pc4;
				widx = LINK_REG;
				wr   = 1'b1;
				npc  = (pc4 & PC_REGION_MASK) | {4'd0, imm, 2'b00};
			end
			default: ;
		endcase

		if (wr)
			gpr[widx] = val;
		else begin
			val  = '0;
			widx = '0;
		end
		pc = npc;

		r.npc  = npc;
		r.wr   = wr;
		r.widx = widx;
		r.wval = val;
		r.ovf  = ovf;
		r.mis  = mis;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Offer one instruction beat after a random gap; predict it once accepted
	task automatic send_instr(input logic [4:0] code, input logic [4:0] rd,
			input logic [4:0] rs, input logic [4:0] rt, input logic [4:0] sh,
			input logic [25:0] imm);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		op           <= code;
		dest_index   <= rd;
		src_index    <= rs;
		tgt_index    <= rt;
		shift_amount <= sh;
		immediate    <= imm;
		do @(posedge clk); while (in_ready !== 1'b1);
		retire_queue.push_back(run_instr(code, rd, rs, rt, sh, imm));
		sent_count++;
	endtask

	task automatic send_r(input op_t code, input logic [4:0] rd, input logic [4:0] rs,
			input logic [4:0] rt, input logic [4:0] sh);
		send_instr(code, rd, rs, rt, sh, 26'($urandom()));
	endtask

	task automatic send_i(input op_t code, input logic [4:0] rt, input logic [4:0] rs,
			input logic [15:0] imm16);
		send_instr(code, 5'($urandom()), rs, rt, 5'($urandom()), {10'($urandom()), imm16});
	endtask

	task automatic send_j(input logic [4:0] code, input logic [25:0] target);
		send_instr(code, 5'($urandom()), 5'($urandom()), 5'($urandom()), 5'($urandom()),
			target);
	endtask

	task automatic send_random_instr();
		send_instr(5'($urandom()), 5'($urandom()), 5'($urandom()), 5'($urandom()),
			5'($urandom()), 26'($urandom()));
	endtask

	// Pull a base into range with andi, then run a few loads and stores off it
	task automatic send_mem_burst();
		logic [4:0]  base, data_reg;
		logic [15:0] mask, offset;
		int          n;
		base = 5'($urandom());
		case ($urandom_range(0, 2))
			0:       mask = 16'h03FF;
			1:       mask = 16'h03FC;
			default: mask = 16'h003F;
		endcase
		send_i(OP_ANDI, base, 5'($urandom()), mask);
		n = $urandom_range(1, 4);
		repeat (n) begin
			data_reg = 5'($urandom());
			if (data_reg == base)
				data_reg = data_reg ^ 5'd1;
			if ($urandom_range(0, 4) == 0)
				offset = 16'($urandom());
			else
				offset = 16'($urandom_range(0, 32) - 16);
			send_i(op_t'($urandom_range(OP_LW, OP_SB)), data_reg, base, offset);
		end
	endtask

	task automatic test_alu_ops();
		send_i(OP_LUI, 5'd1, 5'd0, 16'h8000);
		send_i(OP_NORI, 5'd2, 5'd0, 16'h0000);
		send_i(OP_ORI, 5'd3, 5'd0, 16'hFFFF);
		send_r(OP_ADD, 5'd4, 5'd1, 5'd2, 5'd0);
		send_r(OP_SUB, 5'd5, 5'd1, 5'd3, 5'd0);
		send_r(OP_AND, 5'd6, 5'd2, 5'd3, 5'd0);
		send_r(OP_OR, 5'd7, 5'd1, 5'd3, 5'd0);
		send_r(OP_XOR, 5'd8, 5'd2, 5'd3, 5'd0);
		send_r(OP_NOR, 5'd9, 5'd1, 5'd3, 5'd0);
		send_r(OP_NAND, 5'd10, 5'd2, 5'd2, 5'd0);
		send_r(OP_SLT, 5'd11, 5'd1, 5'd3, 5'd0);
		send_r(OP_SLL, 5'd12, 5'd0, 5'd2, 5'd31);
		send_r(OP_SRL, 5'd13, 5'd0, 5'd1, 5'd31);
		send_r(OP_SRA, 5'd14, 5'd0, 5'd1, 5'd31);
	endtask

	task automatic test_immediate_ops();
		send_i(OP_ADDI, 5'd15, 5'd4, 16'h8000);
		send_i(OP_ANDI, 5'd16, 5'd2, 16'hFFFF);
		send_i(OP_SLTI, 5'd17, 5'd1, 16'hFFFF);
		send_i(OP_LUI, 5'd18, 5'd0, 16'hFFFF);
	endtask

	// Base register 0 still holds zero here, so offsets are absolute addresses
	task automatic test_load_store_edges();
		send_i(OP_SW, 5'd1, 5'd0, 16'd1020);
		send_i(OP_LW, 5'd19, 5'd0, 16'd1020);
		send_i(OP_LH, 5'd20, 5'd0, 16'd1020);
		send_i(OP_LHU, 5'd21, 5'd0, 16'd1020);
		send_i(OP_LB, 5'd22, 5'd0, 16'd1020);
		send_i(OP_SH, 5'd3, 5'd0, 16'd1022);
		send_i(OP_SB, 5'd4, 5'd0, 16'd1023);
		send_i(OP_LBU, 5'd23, 5'd0, 16'd1023);
		// past the end and unaligned at once
		send_i(OP_LW, 5'd24, 5'd0, 16'd1022);
		// negative address
		send_i(OP_LB, 5'd25, 5'd0, 16'hFFFF);
		// unaligned half inside memory
		send_i(OP_LH, 5'd26, 5'd0, 16'd1);
	endtask

	task automatic test_control_flow();
		send_i(OP_BEQ, 5'd0, 5'd10, 16'h8000);
		send_i(OP_BNE, 5'd1, 5'd1, 16'h7FFF);
		send_i(OP_BNE, 5'd2, 5'd1, 16'h7FFF);
		send_j(OP_J, 26'h3FF_FFFF);
		send_j(OP_JAL, 26'h000_0000);
		send_r(OP_JR, 5'($urandom()), 5'd1, 5'($urandom()), 5'($urandom()));
		send_j(OP_RSVD_A, 26'($urandom()));
		send_j(OP_RSVD_B, 26'($urandom()));
		// register zero takes writes like any other
		send_i(OP_ADDI, 5'd0, 5'd0, 16'd5);
		send_r(OP_JR, 5'($urandom()), 5'd0, 5'($urandom()), 5'($urandom()));
	endtask

	// Stall the result side for a long stretch while beats keep coming
	task automatic test_backpressure();
		hold_request <= 1'b1;
		repeat (8) begin
			send_mem_burst();
			send_random_instr();
		end
		hold_request <= 1'b0;
	endtask

	task automatic test_random_stream();
		int stop_at;
		stop_at = sent_count + RANDOM_ITEMS;
		while (sent_count < stop_at) begin
			if ($urandom_range(0, 1) == 0)
				send_mem_burst();
			else
				send_random_instr();
		end
	endtask

	// Hold the receiver off once per request
	initial begin : hold_timer
		hold_active <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request === 1'b1) begin
				hold_active <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active <= 1'b0;
				wait (hold_request !== 1'b1);
			end
		end
	end

	// Result side: random stall before each beat, plus the long hold
	initial begin : result_sink
		int stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, 3);
			if (stall > 0 || hold_active) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
				while (hold_active) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// Compare each result beat against the oldest prediction
	always @(posedge clk) begin : check_results
		retire_t expected;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (retire_queue.size() == 0)
				report_mismatch("result beat with nothing pending", next_pc, '0);
			else begin
				expected = retire_queue.pop_front();
				if (next_pc !== expected.npc)
					report_mismatch("next_pc", next_pc, expected.npc);
				if (reg_write !== expected.wr)
					report_mismatch("reg_write", 32'(reg_write), 32'(expected.wr));
				if (written_index !== expected.widx)
					report_mismatch("written_index", 32'(written_index), 32'(expected.widx));
				if (written_value !== expected.wval)
					report_mismatch("written_value", written_value, expected.wval);
				if (address_overflow !== expected.ovf)
					report_mismatch("address_overflow", 32'(address_overflow),
						32'(expected.ovf));
				if (misaligned !== expected.mis)
					report_mismatch("misaligned", 32'(misaligned), 32'(expected.mis));
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL mips_subset_execute_unit");
			$finish;
		end
	end

	initial begin
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		op           <= OP_ADD;
		dest_index   <= '0;
		src_index    <= '0;
		tgt_index    <= '0;
		shift_amount <= '0;
		immediate    <= '0;
		hold_request <= 1'b0;
		pc = '0;
		foreach (gpr[i])
			gpr[i] = '0;
		foreach (dmem[i])
			dmem[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_alu_ops();
		test_immediate_ops();
		test_load_store_edges();
		test_control_flow();
		test_backpressure();
		test_random_stream();
		in_valid <= 1'b0;

		// Drain outstanding results, then let the pipeline settle
		while (retire_queue.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS mips_subset_execute_unit");
		else
			$display("FAIL mips_subset_execute_unit");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/mse_pkg.sv
sv/mse_regfile.sv
sv/mse_alu.sv
sv/mse_dmem.sv
sv/mips_subset_execute_unit.sv
bench/testbench.sv
